// ----- sv/look_at_view_matrix_core_macros.svh -----
// Assertion helpers for the checker file.
`ifndef LOOK_AT_VIEW_MATRIX_CORE_MACROS_SVH
`define LOOK_AT_VIEW_MATRIX_CORE_MACROS_SVH

// same-cycle implication
`define LAV_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lav check failed");

// next-cycle implication
`define LAV_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lav check failed");

`endif

// ----- sv/lav_pkg.sv -----
package lav_pkg;
    localparam int COORD_W  = 32;              // Q16.16 coordinate width
    localparam int FRAC_W   = 16;              // fraction bits
    localparam int DIFF_W   = COORD_W + 1;     // target - eye
    localparam int NORM_MSB = 29;              // normalized max lies in [2^29, 2^30)
    localparam int NORM_W   = NORM_MSB + 1;
    localparam int SQ_W     = 2 * NORM_W + 2;  // sum of three squares
    localparam int ROOT_STEPS = SQ_W / 2;
    localparam int ROOT_W   = ROOT_STEPS + 1;
    localparam int QUO_W    = FRAC_W + 1;      // unit component magnitude
    localparam int NUM_W    = NORM_W + FRAC_W + 1;
    localparam int UNIT_W   = FRAC_W + 2;      // signed unit component
    localparam int PROD_W   = 2 * UNIT_W;      // unit x unit product
    localparam int RX_W     = PROD_W + 1;      // cross product component
    localparam int AX_W     = FRAC_W + 4;      // stored axis component
    localparam int DP_W     = COORD_W + AX_W;  // |eye| x |axis|
    localparam int DS_W     = DP_W + 2;        // signed sum of three

    localparam logic [1:0] ROW_X  = 2'd0;
    localparam logic [1:0] ROW_Y  = 2'd1;
    localparam logic [1:0] ROW_Z  = 2'd2;
    localparam logic [1:0] ROW_TR = 2'd3;
endpackage

// ----- sv/lav_in_if.sv -----
interface lav_in_if;
    import lav_pkg::*;
    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] eye_x;
    logic signed [COORD_W-1:0] eye_y;
    logic signed [COORD_W-1:0] eye_z;
    logic signed [COORD_W-1:0] target_x;
    logic signed [COORD_W-1:0] target_y;
    logic signed [COORD_W-1:0] target_z;
    logic signed [COORD_W-1:0] up_x;
    logic signed [COORD_W-1:0] up_y;
    logic signed [COORD_W-1:0] up_z;

    modport source (output valid, eye_x, eye_y, eye_z, target_x, target_y, target_z,
                    up_x, up_y, up_z, input ready);
    modport sink   (input valid, eye_x, eye_y, eye_z, target_x, target_y, target_z,
                    up_x, up_y, up_z, output ready);
endinterface

// ----- sv/lav_out_if.sv -----
interface lav_out_if;
    import lav_pkg::*;
    logic                      valid;
    logic                      ready;
    logic [1:0]                row_index;
    logic signed [COORD_W-1:0] col0;
    logic signed [COORD_W-1:0] col1;
    logic signed [COORD_W-1:0] col2;
    logic                      last_row;
    logic                      degenerate;

    modport source (output valid, row_index, col0, col1, col2, last_row, degenerate,
                    input ready);
    modport sink   (input valid, row_index, col0, col1, col2, last_row, degenerate,
                    output ready);
endinterface

// ----- sv/lav_unit.sv -----
// Pipelined vector normalizer: common shift, sum of squares, bit-per-stage
// square root, bit-per-stage division for each component.
module lav_unit #(
    parameter int IN_W   = 33,
    parameter int SIDE_W = 1
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic                              i_valid,
    input  logic [IN_W-1:0]                   i_mag [3],
    input  logic [2:0]                        i_neg,
    input  logic [SIDE_W-1:0]                 i_side,
    output logic                              o_valid,
    output logic signed [lav_pkg::UNIT_W-1:0] o_u [3],
    output logic                              o_zero,
    output logic [SIDE_W-1:0]                 o_side
);
    import lav_pkg::*;

    localparam int PW     = $clog2(IN_W + 1);
    localparam int NEG_LO = SIDE_W + 3 * NORM_W;
    localparam int ZERO_B = NEG_LO + 3;
    localparam int CAR_W  = ZERO_B + 1;

    // stage 0: input register and max
    logic                 r0_v;
    logic [IN_W-1:0]      r0_m [3];
    logic [2:0]           r0_neg;
    logic [SIDE_W-1:0]    r0_side;
    logic [IN_W-1:0]      r0_mx;
    logic [IN_W-1:0]      n0_mx;

    always_comb begin
        n0_mx = i_mag[0];
        if (i_mag[1] > n0_mx) n0_mx = i_mag[1];
        if (i_mag[2] > n0_mx) n0_mx = i_mag[2];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_v <= 1'b0;
        end else if (i_en) begin
            r0_v    <= i_valid;
            r0_m    <= i_mag;
            r0_neg  <= i_neg;
            r0_side <= i_side;
            r0_mx   <= n0_mx;
        end
    end

    // stage 1: leading one position
    logic                 r1_v;
    logic [PW-1:0]        r1_p;
    logic                 r1_zero;
    logic [IN_W-1:0]      r1_m [3];
    logic [2:0]           r1_neg;
    logic [SIDE_W-1:0]    r1_side;
    logic [PW-1:0]        n1_p;

    always_comb begin
        n1_p = '0;
        for (int b = 0; b < IN_W; b++) begin
            if (r0_mx[b]) n1_p = PW'(b);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (i_en) begin
            r1_v    <= r0_v;
            r1_p    <= n1_p;
            r1_zero <= (r0_mx == '0);
            r1_m    <= r0_m;
            r1_neg  <= r0_neg;
            r1_side <= r0_side;
        end
    end

    // stage 2: shift all components so the max lands at NORM_MSB
    logic             r2_v;
    logic [CAR_W-1:0] r2_car;
    logic [NORM_W-1:0] n2_m [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n2_m[i] = NORM_W'({r1_m[i], {NORM_MSB{1'b0}}} >> r1_p);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (i_en) begin
            r2_v   <= r1_v;
            r2_car <= {r1_zero, r1_neg, n2_m[0], n2_m[1], n2_m[2], r1_side};
        end
    end

    // stage 3: squares
    logic                   r3_v;
    logic [CAR_W-1:0]       r3_car;
    logic [2*NORM_W-1:0]    r3_sq [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (i_en) begin
            r3_v   <= r2_v;
            r3_car <= r2_car;
            for (int i = 0; i < 3; i++) begin
                r3_sq[i] <= r2_car[SIDE_W + (2 - i) * NORM_W +: NORM_W]
                          * r2_car[SIDE_W + (2 - i) * NORM_W +: NORM_W];
            end
        end
    end

    // stage 4: sum of squares
    logic             r4_v;
    logic [CAR_W-1:0] r4_car;
    logic [SQ_W-1:0]  r4_s;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
        end else if (i_en) begin
            r4_v   <= r3_v;
            r4_car <= r3_car;
            r4_s   <= SQ_W'(r3_sq[0]) + SQ_W'(r3_sq[1]) + SQ_W'(r3_sq[2]);
        end
    end

    // square root, one result bit per stage
    logic             rt_v   [ROOT_STEPS];
    logic [SQ_W-1:0]  rt_s   [ROOT_STEPS];
    logic [SQ_W-1:0]  rt_r   [ROOT_STEPS];
    logic [CAR_W-1:0] rt_car [ROOT_STEPS];

    for (genvar k = 0; k < ROOT_STEPS; k++) begin : g_root
        localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2 * (ROOT_STEPS - 1 - k));
        logic             v_in;
        logic [SQ_W-1:0]  s_in;
        logic [SQ_W-1:0]  r_in;
        logic [CAR_W-1:0] car_in;
        logic [SQ_W-1:0]  trial;

        if (k == 0) begin : g_first
            assign v_in   = r4_v;
            assign s_in   = r4_s;
            assign r_in   = '0;
            assign car_in = r4_car;
        end else begin : g_next
            assign v_in   = rt_v[k-1];
            assign s_in   = rt_s[k-1];
            assign r_in   = rt_r[k-1];
            assign car_in = rt_car[k-1];
        end

        assign trial = r_in + BIT;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                rt_v[k] <= 1'b0;
            end else if (i_en) begin
                rt_v[k]   <= v_in;
                rt_car[k] <= car_in;
                if (s_in >= trial) begin
                    rt_s[k] <= s_in - trial;
                    rt_r[k] <= (r_in >> 1) + BIT;
                end else begin
                    rt_s[k] <= s_in;
                    rt_r[k] <= r_in >> 1;
                end
            end
        end
    end

    // division setup: numerator m * 2^F + floor(root / 2)
    logic              ri_v;
    logic [CAR_W-1:0]  ri_car;
    logic [ROOT_W-1:0] ri_d;
    logic [NUM_W-1:0]  ri_rem [3];
    logic [QUO_W-1:0]  ri_q   [3];
    logic [ROOT_W-1:0] root;

    assign root = rt_r[ROOT_STEPS-1][ROOT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            ri_v <= 1'b0;
        end else if (i_en) begin
            ri_v   <= rt_v[ROOT_STEPS-1];
            ri_car <= rt_car[ROOT_STEPS-1];
            ri_d   <= root;
            for (int i = 0; i < 3; i++) begin
                ri_rem[i] <= (NUM_W'(rt_car[ROOT_STEPS-1][SIDE_W + (2 - i) * NORM_W +: NORM_W])
                              << FRAC_W) + NUM_W'(root >> 1);
                ri_q[i]   <= '0;
            end
        end
    end

    // restoring division, one quotient bit per stage
    logic              dv_v   [QUO_W];
    logic [CAR_W-1:0]  dv_car [QUO_W];
    logic [ROOT_W-1:0] dv_d   [QUO_W];
    logic [NUM_W-1:0]  dv_rem [QUO_W][3];
    logic [QUO_W-1:0]  dv_q   [QUO_W][3];

    for (genvar j = 0; j < QUO_W; j++) begin : g_div
        localparam int SH = QUO_W - 1 - j;
        logic              v_in;
        logic [CAR_W-1:0]  car_in;
        logic [ROOT_W-1:0] d_in;
        logic [NUM_W-1:0]  rem_in [3];
        logic [QUO_W-1:0]  q_in   [3];
        logic [NUM_W-1:0]  dd;

        if (j == 0) begin : g_first
            assign v_in   = ri_v;
            assign car_in = ri_car;
            assign d_in   = ri_d;
            assign rem_in = ri_rem;
            assign q_in   = ri_q;
        end else begin : g_next
            assign v_in   = dv_v[j-1];
            assign car_in = dv_car[j-1];
            assign d_in   = dv_d[j-1];
            assign rem_in = dv_rem[j-1];
            assign q_in   = dv_q[j-1];
        end

        assign dd = NUM_W'(d_in) << SH;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                dv_v[j] <= 1'b0;
            end else if (i_en) begin
                dv_v[j]   <= v_in;
                dv_car[j] <= car_in;
                dv_d[j]   <= d_in;
                for (int i = 0; i < 3; i++) begin
                    if (rem_in[i] >= dd) begin
                        dv_rem[j][i] <= rem_in[i] - dd;
                        dv_q[j][i]   <= q_in[i] | (QUO_W'(1) << SH);
                    end else begin
                        dv_rem[j][i] <= rem_in[i];
                        dv_q[j][i]   <= q_in[i];
                    end
                end
            end
        end
    end

    // output: sign back, zero vector forces zeros
    logic [CAR_W-1:0] last_car;
    assign last_car = dv_car[QUO_W-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= dv_v[QUO_W-1];
            o_zero  <= last_car[ZERO_B];
            o_side  <= last_car[SIDE_W-1:0];
            for (int i = 0; i < 3; i++) begin
                if (last_car[ZERO_B]) begin
                    o_u[i] <= '0;
                end else if (last_car[NEG_LO + i]) begin
                    o_u[i] <= -$signed(UNIT_W'(dv_q[QUO_W-1][i]));
                end else begin
                    o_u[i] <= $signed(UNIT_W'(dv_q[QUO_W-1][i]));
                end
            end
        end
    end
endmodule

// ----- sv/look_at_view_matrix_core.sv -----
// Left-handed look-at view matrix in signed Q16.16. Each input item (eye,
// target, up hint) produces four result items: rows 0..2 carry (right, up,
// forward) component i, row 3 carries the translation -dot(axis, eye),
// rounded half away from zero and saturated. A zero forward, zero up hint or
// zero right axis sets degenerate and zeroes all columns of the four rows.
// Sustained rate is set by the output row serializer, which emits one row per
// cycle while o_out.ready is high; the compute pipeline itself can take an
// item every cycle and stalls as a whole while the serializer is full.
// From input accept to row 0 valid an item passes two normalizers in series,
// each 55 stages (shift, squares, 31-stage square root, 17-stage divider),
// plus cross product, rounding, dot product and serializer stages.
// No clearing pass or warm-up after reset.
module look_at_view_matrix_core (
    input  logic      i_clk,
    input  logic      i_rst_n,
    lav_in_if.sink    i_in,
    lav_out_if.source o_out
);
    import lav_pkg::*;

    localparam int SIDE_R_W = 1 + 3 * UNIT_W + 3 * COORD_W;

    logic adv;     // whole pipeline moves
    logic ser_load;
    logic out_fire;

    // ---------------- forward and up normalizers (in parallel) ----------------
    logic signed [DIFF_W-1:0] diff [3];
    logic [DIFF_W-1:0]        dmag [3];
    logic [2:0]               dneg;
    logic [COORD_W-1:0]       umag [3];
    logic [2:0]               uneg;
    logic signed [COORD_W-1:0] tgt_v [3];
    logic signed [COORD_W-1:0] eye_v [3];
    logic signed [COORD_W-1:0] up_v  [3];

    assign eye_v = '{i_in.eye_x, i_in.eye_y, i_in.eye_z};
    assign tgt_v = '{i_in.target_x, i_in.target_y, i_in.target_z};
    assign up_v  = '{i_in.up_x, i_in.up_y, i_in.up_z};

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            diff[i] = DIFF_W'(tgt_v[i]) - DIFF_W'(eye_v[i]);
            dneg[i] = diff[i][DIFF_W-1];
            dmag[i] = dneg[i] ? DIFF_W'(-diff[i]) : DIFF_W'(diff[i]);
            uneg[i] = up_v[i][COORD_W-1];
            umag[i] = uneg[i] ? COORD_W'(-up_v[i]) : COORD_W'(up_v[i]);
        end
    end

    logic                      f_v, u_v, f_zero, u_zero;
    logic signed [UNIT_W-1:0]  f_u [3];
    logic signed [UNIT_W-1:0]  u_u [3];
    logic [2*COORD_W-1:0]      f_side;
    logic [COORD_W-1:0]        u_side;

    // eye x,y ride with forward, eye z with the up hint
    lav_unit #(.IN_W(DIFF_W), .SIDE_W(2 * COORD_W)) u_fwd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (i_in.valid),
        .i_mag   (dmag),
        .i_neg   (dneg),
        .i_side  ({i_in.eye_x, i_in.eye_y}),
        .o_valid (f_v),
        .o_u     (f_u),
        .o_zero  (f_zero),
        .o_side  (f_side)
    );

    lav_unit #(.IN_W(COORD_W), .SIDE_W(COORD_W)) u_up (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (i_in.valid),
        .i_mag   (umag),
        .i_neg   (uneg),
        .i_side  (i_in.eye_z),
        .o_valid (u_v),
        .o_u     (u_u),
        .o_zero  (u_zero),
        .o_side  (u_side)
    );

    // ---------------- stage C: collect ----------------
    logic                      r_c_v, r_c_bad;
    logic signed [UNIT_W-1:0]  r_c_fwd [3];
    logic signed [UNIT_W-1:0]  r_c_upn [3];
    logic [3*COORD_W-1:0]      r_c_eye;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_v <= 1'b0;
        end else if (adv) begin
            r_c_v   <= f_v & u_v;
            r_c_bad <= f_zero | u_zero;
            r_c_fwd <= f_u;
            r_c_upn <= u_u;
            r_c_eye <= {f_side, u_side};
        end
    end

    // ---------------- stage D: products of cross(up, fwd) ----------------
    logic                      r_d_v, r_d_bad;
    logic signed [PROD_W-1:0]  r_d_p [6];
    logic signed [UNIT_W-1:0]  r_d_fwd [3];
    logic [3*COORD_W-1:0]      r_d_eye;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_v <= 1'b0;
        end else if (adv) begin
            r_d_v    <= r_c_v;
            r_d_bad  <= r_c_bad;
            r_d_fwd  <= r_c_fwd;
            r_d_eye  <= r_c_eye;
            r_d_p[0] <= r_c_upn[1] * r_c_fwd[2];
            r_d_p[1] <= r_c_upn[2] * r_c_fwd[1];
            r_d_p[2] <= r_c_upn[2] * r_c_fwd[0];
            r_d_p[3] <= r_c_upn[0] * r_c_fwd[2];
            r_d_p[4] <= r_c_upn[0] * r_c_fwd[1];
            r_d_p[5] <= r_c_upn[1] * r_c_fwd[0];
        end
    end

    // ---------------- right normalizer ----------------
    logic signed [RX_W-1:0] rx [3];
    logic [RX_W-1:0]        rxm [3];
    logic [2:0]             rxn;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            rx[i]  = RX_W'(r_d_p[2*i]) - RX_W'(r_d_p[2*i+1]);
            rxn[i] = rx[i][RX_W-1];
            rxm[i] = rxn[i] ? RX_W'(-rx[i]) : RX_W'(rx[i]);
        end
    end

    logic                      rg_v, rg_zero;
    logic signed [UNIT_W-1:0]  rg_u [3];
    logic [SIDE_R_W-1:0]       rg_side;

    lav_unit #(.IN_W(RX_W), .SIDE_W(SIDE_R_W)) u_right (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (r_d_v),
        .i_mag   (rxm),
        .i_neg   (rxn),
        .i_side  ({r_d_bad, r_d_fwd[0], r_d_fwd[1], r_d_fwd[2], r_d_eye}),
        .o_valid (rg_v),
        .o_u     (rg_u),
        .o_zero  (rg_zero),
        .o_side  (rg_side)
    );

    // ---------------- stage F: unpack ----------------
    logic                      r_f_v, r_f_bad;
    logic signed [UNIT_W-1:0]  r_f_rgt [3];
    logic signed [UNIT_W-1:0]  r_f_fwd [3];
    logic signed [COORD_W-1:0] r_f_eye [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_v <= 1'b0;
        end else if (adv) begin
            r_f_v   <= rg_v;
            r_f_bad <= rg_side[SIDE_R_W-1] | rg_zero;
            r_f_rgt <= rg_u;
            for (int i = 0; i < 3; i++) begin
                r_f_fwd[i] <= rg_side[3*COORD_W + (2 - i) * UNIT_W +: UNIT_W];
                r_f_eye[i] <= rg_side[(2 - i) * COORD_W +: COORD_W];
            end
        end
    end

    // ---------------- stage G: products of cross(fwd, right) ----------------
    logic                      r_g_v, r_g_bad;
    logic signed [PROD_W-1:0]  r_g_p [6];
    logic signed [UNIT_W-1:0]  r_g_rgt [3];
    logic signed [UNIT_W-1:0]  r_g_fwd [3];
    logic signed [COORD_W-1:0] r_g_eye [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g_v <= 1'b0;
        end else if (adv) begin
            r_g_v    <= r_f_v;
            r_g_bad  <= r_f_bad;
            r_g_rgt  <= r_f_rgt;
            r_g_fwd  <= r_f_fwd;
            r_g_eye  <= r_f_eye;
            r_g_p[0] <= r_f_fwd[1] * r_f_rgt[2];
            r_g_p[1] <= r_f_fwd[2] * r_f_rgt[1];
            r_g_p[2] <= r_f_fwd[2] * r_f_rgt[0];
            r_g_p[3] <= r_f_fwd[0] * r_f_rgt[2];
            r_g_p[4] <= r_f_fwd[0] * r_f_rgt[1];
            r_g_p[5] <= r_f_fwd[1] * r_f_rgt[0];
        end
    end

    // ---------------- stage H: upward axis, rounded half away from zero ----------------
    logic                      r_h_v, r_h_bad;
    logic signed [AX_W-1:0]    r_h_ax [3][3];   // [axis][component]: right, up, forward
    logic signed [COORD_W-1:0] r_h_eye [3];
    logic signed [RX_W-1:0]    ux [3];
    logic [RX_W-1:0]           uxm [3];
    logic [RX_W-1:0]           uxr [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            ux[i]  = RX_W'(r_g_p[2*i]) - RX_W'(r_g_p[2*i+1]);
            uxm[i] = ux[i][RX_W-1] ? RX_W'(-ux[i]) : RX_W'(ux[i]);
            uxr[i] = (uxm[i] + (RX_W'(1) << (FRAC_W - 1))) >> FRAC_W;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h_v <= 1'b0;
        end else if (adv) begin
            r_h_v   <= r_g_v;
            r_h_bad <= r_g_bad;
            r_h_eye <= r_g_eye;
            for (int i = 0; i < 3; i++) begin
                r_h_ax[0][i] <= AX_W'(r_g_rgt[i]);
                r_h_ax[2][i] <= AX_W'(r_g_fwd[i]);
                if (ux[i][RX_W-1]) r_h_ax[1][i] <= -$signed(AX_W'(uxr[i]));
                else               r_h_ax[1][i] <= $signed(AX_W'(uxr[i]));
            end
        end
    end

    // ---------------- stage I: |axis| x |eye| ----------------
    logic                      r_i_v, r_i_bad;
    logic signed [AX_W-1:0]    r_i_ax [3][3];
    logic [DP_W-1:0]           r_i_p   [3][3];
    logic                      r_i_pos [3][3];  // term adds to -dot
    logic [COORD_W-1:0]        em [3];
    logic [AX_W-1:0]           am [3][3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            em[i] = r_h_eye[i][COORD_W-1] ? COORD_W'(-r_h_eye[i]) : COORD_W'(r_h_eye[i]);
            for (int a = 0; a < 3; a++) begin
                am[a][i] = r_h_ax[a][i][AX_W-1] ? AX_W'(-r_h_ax[a][i]) : AX_W'(r_h_ax[a][i]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_i_v <= 1'b0;
        end else if (adv) begin
            r_i_v   <= r_h_v;
            r_i_bad <= r_h_bad;
            r_i_ax  <= r_h_ax;
            for (int a = 0; a < 3; a++) begin
                for (int i = 0; i < 3; i++) begin
                    r_i_p[a][i]   <= em[i] * am[a][i];
                    r_i_pos[a][i] <= r_h_ax[a][i][AX_W-1] != r_h_eye[i][COORD_W-1];
                end
            end
        end
    end

    // ---------------- stage J: signed sums ----------------
    logic                      r_j_v, r_j_bad;
    logic signed [AX_W-1:0]    r_j_ax [3][3];
    logic signed [DS_W-1:0]    r_j_s  [3];
    logic signed [DS_W-1:0]    term   [3][3];

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            for (int i = 0; i < 3; i++) begin
                term[a][i] = r_i_pos[a][i] ? $signed({2'b00, r_i_p[a][i]})
                                           : -$signed({2'b00, r_i_p[a][i]});
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_j_v <= 1'b0;
        end else if (adv) begin
            r_j_v   <= r_i_v;
            r_j_bad <= r_i_bad;
            r_j_ax  <= r_i_ax;
            for (int a = 0; a < 3; a++) begin
                r_j_s[a] <= term[a][0] + term[a][1] + term[a][2];
            end
        end
    end

    // ---------------- stage K: round and saturate translations ----------------
    logic                      r_k_v, r_k_bad;
    logic signed [AX_W-1:0]    r_k_ax [3][3];
    logic signed [COORD_W-1:0] r_k_tr [3];
    logic [DS_W-1:0]           smag [3];
    logic [DS_W-1:0]           srnd [3];
    logic [DS_W-1:0]           slim [3];
    logic [COORD_W-1:0]        ssel [3];

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            smag[a] = r_j_s[a][DS_W-1] ? DS_W'(-r_j_s[a]) : DS_W'(r_j_s[a]);
            srnd[a] = (smag[a] + (DS_W'(1) << (FRAC_W - 1))) >> FRAC_W;
            slim[a] = r_j_s[a][DS_W-1] ? (DS_W'(1) << (COORD_W - 1))
                                       : ((DS_W'(1) << (COORD_W - 1)) - DS_W'(1));
            ssel[a] = (srnd[a] > slim[a]) ? COORD_W'(slim[a]) : COORD_W'(srnd[a]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k_v <= 1'b0;
        end else if (adv) begin
            r_k_v   <= r_j_v;
            r_k_bad <= r_j_bad;
            r_k_ax  <= r_j_ax;
            for (int a = 0; a < 3; a++) begin
                if (r_j_s[a][DS_W-1]) r_k_tr[a] <= -$signed(ssel[a]);
                else                  r_k_tr[a] <= $signed(ssel[a]);
            end
        end
    end

    // ---------------- row serializer ----------------
    logic                      r_busy;
    logic [1:0]                r_row;
    logic                      r_bad;
    logic signed [AX_W-1:0]    r_ax [3][3];
    logic signed [COORD_W-1:0] r_tr [3];

    assign out_fire = r_busy & o_out.ready;
    // next matrix loads when empty or when the last row leaves this cycle
    assign ser_load = r_k_v & (~r_busy | (out_fire & (r_row == ROW_TR)));
    assign adv      = ~r_k_v | ser_load;
    assign i_in.ready = adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_row  <= ROW_X;
        end else if (ser_load) begin
            r_busy <= 1'b1;
            r_row  <= ROW_X;
            r_bad  <= r_k_bad;
            r_ax   <= r_k_ax;
            r_tr   <= r_k_tr;
        end else if (out_fire) begin
            if (r_row == ROW_TR) r_busy <= 1'b0;
            r_row <= r_row + 2'd1;
        end
    end

    logic signed [COORD_W-1:0] col [3];

    always_comb begin
        case (r_row)
            ROW_X: begin
                for (int a = 0; a < 3; a++) col[a] = COORD_W'(r_ax[a][0]);
            end
            ROW_Y: begin
                for (int a = 0; a < 3; a++) col[a] = COORD_W'(r_ax[a][1]);
            end
            ROW_Z: begin
                for (int a = 0; a < 3; a++) col[a] = COORD_W'(r_ax[a][2]);
            end
            default: begin
                col = r_tr;
            end
        endcase
        if (r_bad) begin
            for (int a = 0; a < 3; a++) col[a] = '0;
        end
    end

    assign o_out.valid      = r_busy;
    assign o_out.row_index  = r_row;
    assign o_out.col0       = col[0];
    assign o_out.col1       = col[1];
    assign o_out.col2       = col[2];
    assign o_out.last_row   = (r_row == ROW_TR);
    assign o_out.degenerate = r_bad;
endmodule

// ----- sv/lav_checker.sv -----
`include "look_at_view_matrix_core_macros.svh"

module lav_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_out_valid,
    input logic                               i_out_ready,
    input logic [1:0]                         i_row_index,
    input logic signed [lav_pkg::COORD_W-1:0] i_col0,
    input logic signed [lav_pkg::COORD_W-1:0] i_col1,
    input logic signed [lav_pkg::COORD_W-1:0] i_col2,
    input logic                               i_last_row,
    input logic                               i_degenerate
);
    import lav_pkg::*;

    // a waiting row holds its number
    `LAV_ASSERT_NXT(a_row_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_row_index))
    // last_row marks the translation row
    `LAV_ASSERT_IMP(a_last_row, i_clk, i_rst_n, i_out_valid, i_last_row == (i_row_index == ROW_TR))
    // rows of one matrix follow back to back in order
    `LAV_ASSERT_NXT(a_row_seq, i_clk, i_rst_n, i_out_valid && i_out_ready && !i_last_row, i_out_valid && (i_row_index == $past(i_row_index) + 2'd1) && $stable(i_degenerate))
    // degenerate matrices are all zero
    `LAV_ASSERT_IMP(a_degen_zero, i_clk, i_rst_n, i_out_valid && i_degenerate, (i_col0 == '0) && (i_col1 == '0) && (i_col2 == '0))
    // every matrix starts at row 0
    `LAV_ASSERT_NXT(a_row_start, i_clk, i_rst_n, i_out_valid && i_out_ready && i_last_row && $past(1'b1), !i_out_valid || (i_row_index == ROW_X))
endmodule

bind look_at_view_matrix_core lav_checker u_lav_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_row_index  (o_out.row_index),
    .i_col0       (o_out.col0),
    .i_col1       (o_out.col1),
    .i_col2       (o_out.col2),
    .i_last_row   (o_out.last_row),
    .i_degenerate (o_out.degenerate)
);
